>>> rtl/ddsw_pkg.sv
package ddsw_pkg;

    localparam int unsigned WORD_BITS_DEF = 16;
    localparam int unsigned CODE_BITS     = 16;
    localparam int unsigned MV_BITS       = 13;

    localparam logic [1:0] MODE_VOLTAGE = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd1;
    localparam logic [1:0] MODE_BOTH    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [1:0]                PREV_MODE_INIT = MODE_NONE;
    localparam logic signed [MV_BITS-1:0] PREV_LEVEL_INIT = 13'sd255;

    localparam logic [CODE_BITS-1:0] MID_CODE = 16'h8000;

    typedef logic [CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic load;
        logic advance;
    } ddsw_shift_ctl_t;

    // Offset binary: level * 8 + 0x8000. A 13-bit level always fits in
    // 0..0xFFF8, so no clamp is needed; the code is the inverted sign
    // followed by the remaining bits and three zeros.
    function automatic code_t level_code(input logic signed [MV_BITS-1:0] mv);
        level_code = {~mv[MV_BITS-1], mv[MV_BITS-2:0], 3'b000};
    endfunction

endpackage

>>> rtl/ddsw_if.sv
interface ddsw_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        channel_mode;
    logic signed [12:0] millivolts;

    modport source (output valid, output channel_mode, output millivolts, input ready);
    modport sink   (input valid, input channel_mode, input millivolts, output ready);
endinterface

interface ddsw_bit_if;
    logic valid;
    logic ready;
    logic target_dac;
    logic serial_bit;
    logic word_end;
    logic last;

    modport source (output valid, output target_dac, output serial_bit,
                    output word_end, output last, input ready);
    modport sink   (input valid, input target_dac, input serial_bit,
                    input word_end, input last, output ready);
endinterface

>>> rtl/ddsw_shifter.sv
module ddsw_shifter #(
    parameter int unsigned WORD_BITS = ddsw_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ddsw_pkg::ddsw_shift_ctl_t ctl,
    input  ddsw_pkg::code_t          code,
    output logic                     data_bit,
    output logic                     word_end
);
    import ddsw_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] shift_reg;
    logic [WORD_BITS-1:0] shift_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (ctl.load)
        begin
            // keep the top bits of the 16-bit code
            shift_next = code[CODE_BITS-1 -: WORD_BITS];
            cnt_next   = '0;
        end
        else if (ctl.advance)
        begin
            shift_next = {shift_reg[WORD_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign data_bit = shift_reg[WORD_BITS-1];
    assign word_end = (cnt_reg == CNT_LAST);

endmodule

>>> rtl/dual_dac_serial_writer.sv
// Channel | Dir | Handshake        | Payload
// req     | in  | valid / ready    | channel_mode[1:0], millivolts[12:0] signed
// bits    | out | valid / ready    | target_dac, serial_bit, word_end, last
//
// A request that writes the converters is accepted and then sent as two output
// words of WORD_BITS bits each, one bit per cycle while bits.ready is high, set by
// the single shift register that serializes both words in turn.
// A repeated request or a no-channel request completes in the accept cycle.
// Reset (rst_n, asynchronous, active low) returns to idle with the previous
// request at mode 3, level 255. A stalled output holds the current bit.
module dual_dac_serial_writer #(
    parameter int unsigned WORD_BITS = ddsw_pkg::WORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ddsw_req_if.sink   req,
    ddsw_bit_if.source bits
);
    import ddsw_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic                      state_reg,  state_next;
    logic                      word_idx_reg, word_idx_next;
    logic                      first_dac_reg, first_dac_next;
    code_t                     level_reg,  level_next;
    logic [1:0]                prev_mode_reg, prev_mode_next;
    logic signed [MV_BITS-1:0] prev_level_reg, prev_level_next;

    ddsw_shift_ctl_t shift_ctl;
    code_t           shift_code;
    logic            shift_bit;
    logic            shift_word_end;

    logic req_fire;
    logic bit_fire;
    logic is_repeat;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign bit_fire  = bits.valid && bits.ready;
    assign is_repeat = (req.channel_mode == prev_mode_reg) &&
                       (req.millivolts == prev_level_reg);

    always_comb
    begin
        state_next      = state_reg;
        word_idx_next   = word_idx_reg;
        first_dac_next  = first_dac_reg;
        level_next      = level_reg;
        prev_mode_next  = prev_mode_reg;
        prev_level_next = prev_level_reg;
        shift_ctl       = '0;
        shift_code      = level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && !is_repeat)
                begin
                    prev_mode_next  = req.channel_mode;
                    prev_level_next = req.millivolts;
                    level_next      = level_code(req.millivolts);
                    // first word: B for voltage mode, A otherwise
                    first_dac_next  = (req.channel_mode == MODE_VOLTAGE);
                    word_idx_next   = 1'b0;
                    shift_code      = (req.channel_mode == MODE_BOTH) ?
                                      level_code(req.millivolts) : MID_CODE;
                    if (req.channel_mode != MODE_NONE)
                    begin
                        shift_ctl.load = 1'b1;
                        state_next     = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (bit_fire)
                begin
                    if (shift_word_end)
                    begin
                        if (!word_idx_reg)
                        begin
                            // second word always carries the level
                            shift_ctl.load = 1'b1;
                            word_idx_next  = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        shift_ctl.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_mode_reg  <= PREV_MODE_INIT;
            prev_level_reg <= PREV_LEVEL_INIT;
        end
        else
        begin
            state_reg      <= state_next;
            prev_mode_reg  <= prev_mode_next;
            prev_level_reg <= prev_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_idx_reg  <= word_idx_next;
        first_dac_reg <= first_dac_next;
        level_reg     <= level_next;
    end

    ddsw_shifter #(
        .WORD_BITS (WORD_BITS)
    ) u_shifter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (shift_ctl),
        .code     (shift_code),
        .data_bit (shift_bit),
        .word_end (shift_word_end)
    );

    // Drive the output straight from the shift register and sequencer state.
    assign bits.valid      = (state_reg == ST_SEND);
    assign bits.target_dac = first_dac_reg ^ word_idx_reg;
    assign bits.serial_bit = shift_bit;
    assign bits.word_end   = shift_word_end;
    assign bits.last       = shift_word_end && word_idx_reg;

endmodule
